// ===== rtl/core/array_address_mapper_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the array address mapper modules.
// ----------------------------------------------------------------------------
`ifndef ARRAY_ADDRESS_MAPPER_UNIT_MACROS_SVH
`define ARRAY_ADDRESS_MAPPER_UNIT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define AAM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define AAM_ASSERT(lbl, prop, msg) `AAM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/aam_pkg.sv =====
// ----------------------------------------------------------------------------
// aam_pkg
// Types, codes and defaults shared by the array address mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aam_pkg;

  // Default configuration of the descriptor table.
  localparam int unsigned ARRAY_SLOTS_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF    = 8;

  // Action codes of an input word.
  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_BOUNDS = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_COUNT = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         array_id;
    logic signed [31:0] base_address;
    logic [15:0]        element_bytes;
    logic [3:0]         dimension_count;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] index_value;
    logic               last_index;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] address;
    logic [1:0]         status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hdr_exec;
    logic bnd_exec;
    logic fin_mul;
    logic fin_upd;
    logic fin_off;
    logic q_mul;
    logic q_acc;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_dup;
    logic bnd_finish;
    logic walk_last;
    logic q_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/aam_channels.sv =====
// ----------------------------------------------------------------------------
// aam_channels
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface aam_in_if;
  logic             valid;
  logic             ready;
  aam_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aam_out_if;
  logic               valid;
  logic               ready;
  aam_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aam_ctrl.sv =====
// ----------------------------------------------------------------------------
// aam_ctrl
// Sequencer that steps the datapath through header, bounds, coefficient
// walk and query phases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_address_mapper_unit_macros.svh"

module aam_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_action_i,
  output logic                 in_ready_o,
  input  aam_pkg::dp_status_t  status_i,
  output aam_pkg::dp_cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_BND  = 3'd2;
  localparam logic [2:0] S_FMUL = 3'd3;
  localparam logic [2:0] S_FUPD = 3'd4;
  localparam logic [2:0] S_FOFF = 3'd5;
  localparam logic [2:0] S_QMUL = 3'd6;
  localparam logic [2:0] S_QACC = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;
  logic       q_start;
  logic [6:0] exec_vec;

  // A word is taken only between operations.
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action_i)
            aam_pkg::ACT_HEADER: state_d = S_HDR;
            aam_pkg::ACT_BOUNDS: state_d = S_BND;
            aam_pkg::ACT_QUERY:  state_d = S_QMUL;
            aam_pkg::ACT_UNUSED: state_d = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        // A duplicate definition needs a free result slot.
        if (!(status_i.hdr_dup && status_i.out_busy)) begin
          cmd_o.hdr_exec = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_BND: begin
        cmd_o.bnd_exec = 1'b1;
        state_d        = status_i.bnd_finish ? S_FMUL : S_IDLE;
      end
      S_FMUL: begin
        cmd_o.fin_mul = 1'b1;
        state_d       = S_FUPD;
      end
      S_FUPD: begin
        cmd_o.fin_upd = 1'b1;
        state_d       = status_i.walk_last ? S_FOFF : S_FMUL;
      end
      S_FOFF: begin
        cmd_o.fin_off = 1'b1;
        state_d       = S_IDLE;
      end
      S_QMUL: begin
        cmd_o.q_mul = 1'b1;
        state_d     = S_QACC;
      end
      S_QACC: begin
        // The last index of a query needs a free result slot.
        if (!(status_i.q_last && status_i.out_busy)) begin
          cmd_o.q_acc = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Signals watched by the assertions.
  assign q_start  = accept && (in_action_i == aam_pkg::ACT_QUERY);
  assign exec_vec = {cmd_o.hdr_exec, cmd_o.bnd_exec, cmd_o.fin_mul, cmd_o.fin_upd,
                     cmd_o.fin_off, cmd_o.q_mul, cmd_o.q_acc};

  `AAM_ASSERT(a_query_mul_next, q_start |=> cmd_o.q_mul, "query word not followed by multiply")
  `AAM_ASSERT(a_single_cmd, $onehot0(exec_vec), "more than one datapath command")
  `AAM_ASSERT(a_walk_order, cmd_o.fin_upd |=> (cmd_o.fin_mul || cmd_o.fin_off), "walk broken")

endmodule

`default_nettype wire

// ===== rtl/core/aam_dpath.sv =====
// ----------------------------------------------------------------------------
// aam_dpath
// Descriptor storage, shared multiplier, coefficient walk and query
// accumulator with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_address_mapper_unit_macros.svh"

module aam_dpath #(
  parameter int unsigned ARRAY_SLOTS = aam_pkg::ARRAY_SLOTS_DEF,
  parameter int unsigned MAX_DIMS    = aam_pkg::MAX_DIMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aam_pkg::in_word_t    in_data_i,
  input  aam_pkg::dp_cmd_t     cmd_i,
  output aam_pkg::dp_status_t  status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output aam_pkg::out_word_t   out_data_o
);

  localparam int unsigned STRIDE = MAX_DIMS + 1;
  localparam int unsigned DEPTH  = ARRAY_SLOTS * STRIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SLOT_W = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
  localparam int unsigned DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int unsigned PIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned COL_W  = $clog2(STRIDE);

  // Descriptor memories, one row of coefficients per slot.
  logic [31:0]       coef_mem [DEPTH];
  logic [DCNT_W-1:0] dims_mem [ARRAY_SLOTS];

  // Control state.
  logic [ARRAY_SLOTS-1:0] def_q;
  logic [DCNT_W-1:0]      pend_dims_q;
  logic [DCNT_W-1:0]      bound_q;
  logic [DCNT_W-1:0]      walk_q;
  logic [DCNT_W-1:0]      qcnt_q;
  logic [1:0]             qerr_q;
  logic [31:0]            acc_q;
  logic                   out_valid_q;

  // Payload state.
  aam_pkg::in_word_t  item_q;
  aam_pkg::out_word_t out_q;
  logic [31:0]        pend_base_q;
  logic [15:0]        pend_elem_q;
  logic [SLOT_W-1:0]  pend_slot_q;
  logic [31:0]        low_q [MAX_DIMS];
  logic [31:0]        ext_q [MAX_DIMS];
  logic [31:0]        cur_q;
  logic [31:0]        off_q;
  logic [31:0]        mul_q;
  logic [31:0]        coef_rd_q;
  logic [31:0]        base_rd_q;
  logic [DCNT_W-1:0]  dims_rd_q;

  // Combinational signals.
  logic              in_ok;
  logic [SLOT_W-1:0] in_row;
  logic [COL_W-1:0]  q_col;
  logic              it_ok;
  logic [SLOT_W-1:0] it_row;
  logic              it_def;
  logic              hdr_dup;
  logic              hdr_load;
  logic [DCNT_W-1:0] hdr_dims;
  logic              bnd_take;
  logic              bnd_finish;
  logic [PIDX_W-1:0] bidx;
  logic [PIDX_W-1:0] jm1;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mul_res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]       mem_wd;
  logic [31:0]       acc_base;
  logic [31:0]       acc_n;
  logic [DCNT_W-1:0] qcnt_n;
  logic [1:0]        qerr_n;
  logic              emit;
  aam_pkg::out_word_t emit_word;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] row,
                                                 input logic [COL_W-1:0]  col);
    return ADDR_W'(int'(row) * STRIDE + int'(col));
  endfunction

  function automatic logic slot_ok(input logic [3:0] id);
    return 32'(id) < ARRAY_SLOTS;
  endfunction

  // Slot selection for the incoming word and for the held word.
  assign in_ok  = slot_ok(in_data_i.array_id);
  assign in_row = in_ok ? SLOT_W'(in_data_i.array_id) : '0;
  assign q_col  = (qcnt_q < DCNT_W'(MAX_DIMS)) ? COL_W'(qcnt_q + DCNT_W'(1)) : '0;
  assign it_ok  = slot_ok(item_q.array_id);
  assign it_row = it_ok ? SLOT_W'(item_q.array_id) : '0;
  assign it_def = it_ok && def_q[it_row];

  // Header decode with the dimension count clamped to the supported range.
  assign hdr_dup  = it_def;
  assign hdr_load = it_ok && !it_def;
  always_comb begin
    if (item_q.dimension_count == 4'd0) begin
      hdr_dims = DCNT_W'(1);
    end else if (32'(item_q.dimension_count) > MAX_DIMS) begin
      hdr_dims = DCNT_W'(MAX_DIMS);
    end else begin
      hdr_dims = DCNT_W'(item_q.dimension_count);
    end
  end

  // Bounds collection.
  assign bnd_take   = (pend_dims_q != '0) && (bound_q < pend_dims_q);
  assign bnd_finish = bnd_take && ((bound_q + DCNT_W'(1)) == pend_dims_q);
  assign bidx       = PIDX_W'(bound_q);
  assign jm1        = PIDX_W'(walk_q - DCNT_W'(1));

  // Shared multiplier, truncated to 32 bits.
  always_comb begin
    if (cmd_i.q_mul) begin
      mul_a = coef_rd_q;
      mul_b = item_q.index_value;
    end else if (cmd_i.fin_mul) begin
      mul_a = cur_q;
      mul_b = low_q[jm1];
    end else begin
      mul_a = cur_q;
      mul_b = ext_q[jm1];
    end
  end
  assign mul_res = mul_a * mul_b;

  // Memory write port: coefficients during the walk, offset at its end.
  assign mem_we = cmd_i.fin_mul || cmd_i.fin_off;
  assign mem_wa = cmd_i.fin_mul ? mem_addr(pend_slot_q, COL_W'(walk_q))
                                : mem_addr(pend_slot_q, '0);
  assign mem_wd = cmd_i.fin_mul ? cur_q : off_q;

  // Query accumulation; the first error of a query is kept.
  always_comb begin
    acc_base = (qcnt_q == '0) ? base_rd_q : acc_q;
    acc_n    = acc_q;
    qcnt_n   = qcnt_q;
    qerr_n   = qerr_q;
    if (qerr_q == aam_pkg::ST_OK) begin
      if (!it_def) begin
        qerr_n = aam_pkg::ST_UNDEF;
      end else begin
        acc_n = acc_base;
        if (qcnt_q >= dims_rd_q) begin
          qerr_n = aam_pkg::ST_COUNT;
        end else begin
          acc_n  = acc_base + mul_q;
          qcnt_n = qcnt_q + DCNT_W'(1);
          if (item_q.last_index && (qcnt_n != dims_rd_q)) begin
            qerr_n = aam_pkg::ST_COUNT;
          end
        end
      end
    end
  end

  // Result selection.
  assign emit = (cmd_i.hdr_exec && hdr_dup) || (cmd_i.q_acc && item_q.last_index);
  always_comb begin
    if (cmd_i.hdr_exec) begin
      emit_word.address = '0;
      emit_word.status  = aam_pkg::ST_DUP;
    end else begin
      emit_word.address = (qerr_n == aam_pkg::ST_OK) ? acc_n : '0;
      emit_word.status  = qerr_n;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q       <= '0;
      pend_dims_q <= '0;
      bound_q     <= '0;
      walk_q      <= '0;
      qcnt_q      <= '0;
      qerr_q      <= aam_pkg::ST_OK;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hdr_exec) begin
        pend_dims_q <= hdr_load ? hdr_dims : '0;
        bound_q     <= '0;
      end
      if (cmd_i.bnd_exec && bnd_take) begin
        bound_q <= bound_q + DCNT_W'(1);
      end
      if (cmd_i.bnd_exec && bnd_finish) begin
        walk_q <= pend_dims_q;
      end
      if (cmd_i.fin_upd) begin
        walk_q <= walk_q - DCNT_W'(1);
      end
      if (cmd_i.fin_off) begin
        def_q[pend_slot_q] <= 1'b1;
        pend_dims_q        <= '0;
        bound_q            <= '0;
      end
      if (cmd_i.q_acc) begin
        if (item_q.last_index) begin
          acc_q  <= '0;
          qcnt_q <= '0;
          qerr_q <= aam_pkg::ST_OK;
        end else begin
          acc_q  <= acc_n;
          qcnt_q <= qcnt_n;
          qerr_q <= qerr_n;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.hdr_exec && hdr_load) begin
      pend_base_q <= item_q.base_address;
      pend_elem_q <= item_q.element_bytes;
      pend_slot_q <= it_row;
    end
    if (cmd_i.bnd_exec && bnd_take) begin
      low_q[bidx] <= item_q.lower_bound;
      ext_q[bidx] <= item_q.upper_bound - item_q.lower_bound + 32'd1;
    end
    if (cmd_i.bnd_exec && bnd_finish) begin
      cur_q <= 32'(pend_elem_q);
      off_q <= pend_base_q;
    end
    if (cmd_i.fin_mul || cmd_i.q_mul) begin
      mul_q <= mul_res;
    end
    if (cmd_i.fin_upd) begin
      off_q <= off_q - mul_q;
      cur_q <= mul_res;
    end
    if (emit) begin
      out_q <= emit_word;
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.fin_off) begin
      dims_mem[pend_slot_q] <= pend_dims_q;
    end
  end

  // Registered memory reads for a query word, taken as it arrives.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      coef_rd_q <= coef_mem[mem_addr(in_row, q_col)];
      base_rd_q <= coef_mem[mem_addr(in_row, '0)];
      dims_rd_q <= dims_mem[in_row];
    end
  end

  assign status_o.hdr_dup    = hdr_dup;
  assign status_o.bnd_finish = bnd_finish;
  assign status_o.walk_last  = (walk_q == DCNT_W'(1));
  assign status_o.q_last     = item_q.last_index;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AAM_ASSERT(a_walk_nonzero, cmd_i.fin_mul |-> (walk_q != '0), "walk index is zero")
  `AAM_ASSERT(a_no_overwrite, emit |-> !status_o.out_busy, "result overwrites a waiting word")
  `AAM_ASSERT(a_qcnt_range, qcnt_q <= DCNT_W'(MAX_DIMS), "query index count out of range")

endmodule

`default_nettype wire

// ===== rtl/core/array_address_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// array_address_mapper_unit: row-major address mapper for array descriptors.
// Header and plain bounds words are taken and executed; the last bounds word
// of a definition also runs the serial coefficient walk on one shared
// multiplier. Query words step through read, multiply and add.
// Reset clears the defined flags and query state; no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module array_address_mapper_unit #(
  parameter int unsigned ARRAY_SLOTS = aam_pkg::ARRAY_SLOTS_DEF,
  parameter int unsigned MAX_DIMS    = aam_pkg::MAX_DIMS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  aam_in_if.sink           in_ch_i,
  aam_out_if.source        out_ch_o
);

  aam_pkg::dp_cmd_t    cmd;
  aam_pkg::dp_status_t status;
  logic                in_ready;

  // Sequencer.
  aam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_action_i (in_ch_i.data.action),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  aam_dpath #(
    .ARRAY_SLOTS (ARRAY_SLOTS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_ch_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .out_data_o  (out_ch_o.data)
  );

  assign in_ch_i.ready = in_ready;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the array address mapper unit
// Feeds header, bounds and query words into the mapper and checks every
// result word against a cycle-free model of the descriptor table. A short
// table of directed words comes first, then random definitions and queries
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = aam_pkg::ARRAY_SLOTS_DEF;
  localparam int DIMS          = aam_pkg::MAX_DIMS_DEF;
  localparam int RANDOM_WORDS  = 950;
  localparam int TAIL_START    = 820;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_WORDS    = 24;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_PRINTS    = 100;

  // One row of the directed table; result is typed in where fixed is set.
  typedef struct packed {
    aam_pkg::in_word_t  word;
    logic               fixed;
    aam_pkg::out_word_t result;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  aam_in_if  in_ch ();
  aam_out_if out_ch ();

  array_address_mapper_unit #(
    .ARRAY_SLOTS(SLOTS),
    .MAX_DIMS   (DIMS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  // Mirror of the descriptor table and of the definition and query in flight.
  logic        slot_defined [SLOTS];
  int          slot_dims    [SLOTS];
  logic [31:0] slot_coef    [SLOTS][DIMS+1];
  logic [31:0] draft_lo     [DIMS];
  logic [31:0] draft_hi     [DIMS];
  logic [31:0] draft_base;
  logic [15:0] draft_elem;
  int          draft_dims;
  int          draft_filled;
  logic [3:0]  draft_id;
  logic [31:0] query_acc;
  int          query_step;
  logic [1:0]  query_status;

  aam_pkg::out_word_t expected_addresses [$];
  stim_row_t          directed_rows [$];
  int          error_count  = 0;
  int          useful_words = 0;
  int          cycle_count  = 0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;
  bit          hold_request = 1'b0;

  always #10ns clk_i = ~clk_i;

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Applies one accepted word to the mirrored state and returns its result.
  function automatic void map_word(input aam_pkg::in_word_t w, output bit has_res,
                                   output aam_pkg::out_word_t res);
    logic [31:0] off;
    int          d;
    int          j;
    has_res = 1'b0;
    res     = '0;
    case (w.action)
      aam_pkg::ACT_HEADER: begin
        // Any header drops the pending definition.
        draft_dims   = 0;
        draft_filled = 0;
        if (slot_defined[w.array_id]) begin
          has_res    = 1'b1;
          res.status = aam_pkg::ST_DUP;
        end else begin
          d = int'(w.dimension_count);
          if (d == 0) d = 1;
          if (d > DIMS) d = DIMS;
          draft_base = w.base_address;
          draft_elem = w.element_bytes;
          draft_dims = d;
          draft_id   = w.array_id;
        end
      end
      aam_pkg::ACT_BOUNDS: begin
        if (draft_dims != 0 && draft_filled < draft_dims) begin
          draft_lo[draft_filled] = w.lower_bound;
          draft_hi[draft_filled] = w.upper_bound;
          draft_filled++;
          if (draft_filled == draft_dims) begin
            // Row-major coefficients from the last dimension backward.
            slot_coef[draft_id][draft_dims] = {16'd0, draft_elem};
            for (j = draft_dims - 1; j > 0; j--) begin
              slot_coef[draft_id][j] = slot_coef[draft_id][j+1] *
                                       (draft_hi[j] - draft_lo[j] + 32'd1);
            end
            off = draft_base;
            for (j = 1; j <= draft_dims; j++) begin
              off = off - draft_lo[j-1] * slot_coef[draft_id][j];
            end
            slot_coef[draft_id][0] = off;
            slot_dims[draft_id]    = draft_dims;
            slot_defined[draft_id] = 1'b1;
            draft_dims   = 0;
            draft_filled = 0;
          end
        end
      end
      aam_pkg::ACT_QUERY: begin
        // The first error of a query sticks until its last word.
        if (query_status == aam_pkg::ST_OK) begin
          if (!slot_defined[w.array_id]) begin
            query_status = aam_pkg::ST_UNDEF;
          end else begin
            if (query_step == 0) query_acc = slot_coef[w.array_id][0];
            if (query_step >= slot_dims[w.array_id]) begin
              query_status = aam_pkg::ST_COUNT;
            end else begin
              query_acc = query_acc +
                          slot_coef[w.array_id][query_step+1] * w.index_value;
              query_step++;
              if (w.last_index && query_step != slot_dims[w.array_id]) begin
                query_status = aam_pkg::ST_COUNT;
              end
            end
          end
        end
        if (w.last_index) begin
          has_res     = 1'b1;
          res.address = (query_status == aam_pkg::ST_OK) ? query_acc : 32'd0;
          res.status  = query_status;
          query_acc    = '0;
          query_step   = 0;
          query_status = aam_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic aam_pkg::in_word_t blank_word(input logic [1:0] act);
    aam_pkg::in_word_t w;
    w        = '0;
    w.action = act;
    return w;
  endfunction

  function automatic aam_pkg::in_word_t hdr_word(input logic [3:0] id,
                                                 input logic [31:0] base,
                                                 input logic [15:0] elem,
                                                 input logic [3:0] dims);
    aam_pkg::in_word_t w;
    w                 = blank_word(aam_pkg::ACT_HEADER);
    w.array_id        = id;
    w.base_address    = base;
    w.element_bytes   = elem;
    w.dimension_count = dims;
    return w;
  endfunction

  function automatic aam_pkg::in_word_t bnd_word(input logic [31:0] lo,
                                                 input logic [31:0] hi);
    aam_pkg::in_word_t w;
    w             = blank_word(aam_pkg::ACT_BOUNDS);
    w.lower_bound = lo;
    w.upper_bound = hi;
    return w;
  endfunction

  function automatic aam_pkg::in_word_t qry_word(input logic [3:0] id,
                                                 input logic [31:0] idx,
                                                 input logic last);
    aam_pkg::in_word_t w;
    w             = blank_word(aam_pkg::ACT_QUERY);
    w.array_id    = id;
    w.index_value = idx;
    w.last_index  = last;
    return w;
  endfunction

  // Every field random, so that fields the action ignores toggle too.
  function automatic aam_pkg::in_word_t random_word(input logic [1:0] act);
    aam_pkg::in_word_t w;
    w.action          = act;
    w.array_id        = 4'($urandom);
    w.base_address    = $urandom;
    w.element_bytes   = 16'($urandom);
    w.dimension_count = 4'($urandom);
    w.lower_bound     = $urandom;
    w.upper_bound     = $urandom;
    w.index_value     = $urandom;
    w.last_index      = 1'($urandom);
    return w;
  endfunction

  function automatic void add_row(input aam_pkg::in_word_t w, input logic fixed,
                                  input logic [1:0] st);
    stim_row_t r;
    r.word           = w;
    r.fixed          = fixed;
    r.result.address = '0;
    r.result.status  = st;
    directed_rows    = {directed_rows, r};
  endfunction

  // Offers one word, waits for its handshake and records what it should cause.
  task automatic drive_word(input aam_pkg::in_word_t w, input logic fixed,
                            input aam_pkg::out_word_t fixed_res);
    bit                 has_res;
    aam_pkg::out_word_t res;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    if (w.action != aam_pkg::ACT_UNUSED &&
        !(w.action == aam_pkg::ACT_BOUNDS && draft_dims == 0)) begin
      useful_words++;
    end
    map_word(w, has_res, res);
    if (fixed) begin
      has_res = 1'b1;
      res     = fixed_res;
    end
    if (has_res) expected_addresses = {expected_addresses, res};
  endtask

  // Holds the input idle until every expected result word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_addresses.size() != 0);
  endtask

  // A header followed by its bounds, mostly into a free slot.
  task automatic define_random();
    aam_pkg::in_word_t w;
    int       free_ids [$];
    int       dims;
    int       span;
    int       k;
    int       lo;
    for (k = 0; k < SLOTS; k++) begin
      if (!slot_defined[k]) free_ids = {free_ids, k};
    end
    w               = random_word(aam_pkg::ACT_HEADER);
    w.element_bytes = 16'($urandom_range(1, 65535));
    if (free_ids.size() > 0 && $urandom_range(0, 9) < 8) begin
      w.array_id = 4'(free_ids[$urandom_range(0, free_ids.size() - 1)]);
    end
    if ($urandom_range(0, 9) != 0) w.dimension_count = 4'($urandom_range(1, DIMS));
    dims = (w.dimension_count == 0) ? 1 :
           (w.dimension_count > DIMS) ? DIMS : int'(w.dimension_count);
    drive_word(w, 1'b0, '0);
    // Some definitions stop short and are replaced by the next header.
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, dims - 1) : dims;
    for (k = 0; k < span; k++) begin
      w = random_word(aam_pkg::ACT_BOUNDS);
      if ($urandom_range(0, 4) != 0) begin
        lo            = $urandom_range(0, 40) - 20;
        w.lower_bound = lo;
        w.upper_bound = lo + $urandom_range(0, 9);
      end
      drive_word(w, 1'b0, '0);
    end
  endtask

  // A run of index words, mostly with the right count on a defined array.
  task automatic query_random();
    aam_pkg::in_word_t w;
    int       known [$];
    int       id;
    int       count;
    int       k;
    for (k = 0; k < SLOTS; k++) begin
      if (slot_defined[k]) known = {known, k};
    end
    if (known.size() == 0 || $urandom_range(0, 9) == 0) begin
      id = $urandom_range(0, SLOTS - 1);
    end else begin
      id = known[$urandom_range(0, known.size() - 1)];
    end
    count = slot_defined[id] ? slot_dims[id] : $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0: count = $urandom_range(1, count);
      1: count = count + $urandom_range(1, 2);
      default: begin
      end
    endcase
    for (k = 0; k < count; k++) begin
      w          = random_word(aam_pkg::ACT_QUERY);
      w.array_id = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, SLOTS - 1))
                                                : 4'(id);
      if ($urandom_range(0, 4) != 0) w.index_value = $urandom_range(0, 50) - 20;
      w.last_index = (k == count - 1);
      drive_word(w, 1'b0, '0);
    end
  endtask

  task automatic run_random(input int target);
    int pick;
    while (useful_words < target) begin
      if (useful_words >= TAIL_START) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        define_random();
      end else if (pick < 90) begin
        query_random();
      end else begin
        drive_word(random_word($urandom_range(0, 1) ? aam_pkg::ACT_UNUSED
                                                    : aam_pkg::ACT_BOUNDS),
                   1'b0, '0);
      end
    end
  endtask

  // Result side: random stall bursts, one long hold-off on request.
  initial begin : result_sink
    int span;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        span = HOLD_CYCLES;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        span = $urandom_range(1, 18);
      end else begin
        out_ch.ready <= 1'b1;
        span = stalls_on ? $urandom_range(1, 30) : 1;
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // Compares each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    aam_pkg::out_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_addresses.size() == 0) begin
        flag_error($sformatf("result word with none expected: address %h status %0d",
                             out_ch.data.address, out_ch.data.status));
      end else begin
        want = expected_addresses.pop_front();
        if (out_ch.data.address !== want.address) begin
          flag_error($sformatf("address %h, expected %h",
                               out_ch.data.address, want.address));
        end
        if (out_ch.data.status !== want.status) begin
          flag_error($sformatf("status %0d, expected %0d",
                               out_ch.data.status, want.status));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int                k;
    aam_pkg::in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    for (k = 0; k < SLOTS; k++) begin
      slot_defined[k] = 1'b0;
      slot_dims[k]    = 0;
    end
    draft_base   = '0;
    draft_elem   = '0;
    draft_dims   = 0;
    draft_filled = 0;
    draft_id     = '0;
    query_acc    = '0;
    query_step   = 0;
    query_status = aam_pkg::ST_OK;

    // Query right after reset, unused action and a stray bounds word.
    add_row(qry_word(4'd0, 32'd0, 1'b1), 1'b1, aam_pkg::ST_UNDEF);
    add_row(blank_word(aam_pkg::ACT_UNUSED), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'd5, 32'd7), 1'b0, aam_pkg::ST_OK);
    // A 10 x 10 array of 4-byte elements and a query into it.
    add_row(hdr_word(4'd0, 32'd1000, 16'd4, 4'd2), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'd0, 32'd9), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'd0, 32'd9), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd0, 32'd3, 1'b0), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd0, 32'd5, 1'b1), 1'b0, aam_pkg::ST_OK);
    add_row(hdr_word(4'd0, 32'd0, 16'd1, 4'd1), 1'b1, aam_pkg::ST_DUP);
    // Extreme fields; a dimension count of zero acts as one.
    add_row(hdr_word(4'd15, 32'h7fff_ffff, 16'hffff, 4'd0), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'h8000_0000, 32'h7fff_ffff), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd15, 32'h7fff_ffff, 1'b1), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd15, 32'h8000_0000, 1'b1), 1'b0, aam_pkg::ST_OK);
    // Too few and too many indices.
    add_row(qry_word(4'd0, 32'd1, 1'b1), 1'b1, aam_pkg::ST_COUNT);
    add_row(qry_word(4'd15, 32'd0, 1'b0), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd15, 32'd0, 1'b1), 1'b1, aam_pkg::ST_COUNT);
    // Oversized dimension count, then a header that replaces it mid-way.
    add_row(hdr_word(4'd3, 32'h8000_0000, 16'd1, 4'd15), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'd1, 32'd2), 1'b0, aam_pkg::ST_OK);
    add_row(hdr_word(4'd4, -32'sd64, 16'd8, 4'd1), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(-32'sd5, 32'sd5), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd3, 32'd0, 1'b1), 1'b1, aam_pkg::ST_UNDEF);
    // A definition landing in the middle of a query leaves the query alone.
    add_row(qry_word(4'd0, 32'd2, 1'b0), 1'b0, aam_pkg::ST_OK);
    add_row(hdr_word(4'd5, 32'd0, 16'd2, 4'd1), 1'b0, aam_pkg::ST_OK);
    add_row(bnd_word(32'd0, 32'd3), 1'b0, aam_pkg::ST_OK);
    add_row(qry_word(4'd0, 32'd7, 1'b1), 1'b0, aam_pkg::ST_OK);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);
    end

    run_random(350);

    // Input pauses until the block has handed back everything.
    drain_results();

    // Result side holds off while the input keeps offering words.
    hold_request = 1'b1;
    gaps_on      = 1'b0;
    for (k = 0; k < HOLD_WORDS; k++) begin
      w            = random_word(aam_pkg::ACT_QUERY);
      w.array_id   = 4'd15;
      w.last_index = 1'b1;
      drive_word(w, 1'b0, '0);
    end
    gaps_on = 1'b1;

    run_random(RANDOM_WORDS);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== array_address_mapper_unit.f =====
+incdir+rtl/core
rtl/core/aam_pkg.sv
rtl/core/aam_channels.sv
rtl/core/aam_ctrl.sv
rtl/core/aam_dpath.sv
rtl/core/array_address_mapper_unit.sv
test/tb_top.sv
